>>> design/vsbd_pkg.sv
// Package for the stop-bit varint decoder.
// Holds the status codes, limits, result record and byte shift table.
// No dependencies.
package vsbd_pkg;

	localparam logic [6:0] PAYLOAD_MASK = 7'h7f;
	localparam int unsigned STOP_BIT = 7;
	localparam logic [3:0] NARROW_LIMIT = 4'd5;
	localparam logic [3:0] WIDE_LIMIT = 4'd10;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVERLONG = 2'd1,
		ST_TRUNC    = 2'd2
	} status_t;

	typedef struct packed {
		logic [63:0] value;
		logic [3:0]  byte_count;
		status_t     status;
	} res_t;

	// Bit position of byte n within a value: 7 * n, n from 0 to 9.
	function automatic logic [5:0] byte_shift(input logic [3:0] n);
		logic [5:0] s;
		case (n)
			4'd0: s = 6'd0;
			4'd1: s = 6'd7;
			4'd2: s = 6'd14;
			4'd3: s = 6'd21;
			4'd4: s = 6'd28;
			4'd5: s = 6'd35;
			4'd6: s = 6'd42;
			4'd7: s = 6'd49;
			4'd8: s = 6'd56;
			4'd9: s = 6'd63;
			default: s = 6'd0;
		endcase
		return s;
	endfunction

endpackage

>>> design/vsbd_accum.sv
// Accumulator and byte counter of the varint decoder.
// Folds one registered byte per cycle into the value while take is high; uses vsbd_pkg.
module vsbd_accum import vsbd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wide_mode,
	input  logic       take,
	input  logic [7:0] data_byte,
	input  logic       stream_end,
	output logic       res_hit,
	output res_t       res
);

	logic [63:0] acc_q;
	logic [3:0]  seen_q;

	logic [63:0] shifted;
	logic [63:0] acc_next;
	logic [3:0]  count;
	logic [3:0]  limit;
	logic        stop;
	logic        over;

	always_comb begin
		shifted  = {57'd0, data_byte[6:0] & PAYLOAD_MASK} << byte_shift(seen_q);
		acc_next = acc_q | shifted;
		if (!wide_mode) begin
			acc_next = {32'd0, acc_next[31:0]};
		end
		count = seen_q + 4'd1;
		limit = wide_mode ? WIDE_LIMIT : NARROW_LIMIT;
		stop  = data_byte[STOP_BIT];
		over  = (count >= limit);

		res_hit        = stream_end || stop || over;
		res.value      = 64'd0;
		res.byte_count = count;
		res.status     = ST_OK;
		if (stream_end) begin
			res.byte_count = seen_q;
			res.status     = ST_TRUNC;
		end else if (stop) begin
			res.value = acc_next;
		end else begin
			res.status = ST_OVERLONG;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= 64'd0;
			seen_q <= 4'd0;
		end else if (take) begin
			if (res_hit) begin
				acc_q  <= 64'd0;
				seen_q <= 4'd0;
			end else begin
				acc_q  <= acc_next;
				seen_q <= count;
			end
		end
	end

endmodule

>>> design/vsbd_out.sv
// Result register of the varint decoder, driving the master stream.
// Uses the result record from vsbd_pkg.
module vsbd_out import vsbd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  res_t        res,
	output logic        can_load,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,
	output logic [1:0]  m_axis_tuser
);

	logic valid_q;
	res_t res_q;

	assign can_load = !valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	// Payload holds while the beat waits.
	always_ff @(posedge clk) begin
		if (can_load && load) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {4'd0, res_q.byte_count, res_q.value};
	assign m_axis_tuser  = res_q.status;

endmodule

>>> design/varint_stop_bit_decoder.sv
// Stop-bit varint decoder: input register, accumulate stage and result register.
// Instantiates vsbd_accum and vsbd_out; uses vsbd_pkg.
//
// Usage:
//   Slave stream carries one encoded byte per beat: s_axis_tdata[7:0] is the
//   byte (bit 7 set marks the last byte of a value); s_axis_tuser high means
//   the source ran dry, and the byte is ignored.
//   Master stream carries one result beat per finished value or error:
//   m_axis_tdata[63:0] value, [67:64] byte count, upper bits zero;
//   m_axis_tuser is the status (ok, overlong, truncated).
//   cfg_we/cfg_wdata write wide_mode (1 = 64-bit up to 10 bytes,
//   0 = 32-bit up to 5 bytes); write only while the decoder is idle.
// Timing:
//   A result passes the input and result registers. One byte is taken every
//   cycle unless a result waits on the result register; the path from the
//   byte register through the accumulator update is one shift-or and count.
// Reset clears the accumulator, byte count and both stage valids and sets
// wide_mode. When the receiver stalls, the result register holds its beat;
// bytes that give no result keep flowing, and a byte that would give one
// waits in the input register until the result register frees up.
module varint_stop_bit_decoder import vsbd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tuser,   // [0] stream_end
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,   // [63:0] value, [67:64] byte_count, [71:68] zero
	output logic [1:0]  m_axis_tuser    // [1:0] status
);

	logic       wide_mode_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;
	logic       res_hit;
	logic       can_load;
	logic       advance;
	res_t       res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_mode_q <= 1'b1;
		end else if (cfg_we) begin
			wide_mode_q <= cfg_wdata;
		end
	end

	// Advance unless a result must wait for the output register.
	assign advance       = valid_s1 && (!res_hit || can_load);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			end_s1  <= s_axis_tuser;
		end
	end

	vsbd_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.wide_mode  (wide_mode_q),
		.take       (advance),
		.data_byte  (byte_s1),
		.stream_end (end_s1),
		.res_hit    (res_hit),
		.res        (res)
	);

	vsbd_out u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (advance && res_hit),
		.res           (res),
		.can_load      (can_load),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

>>> tb/tb_varint_stop_bit_decoder.sv
// Testbench for varint_stop_bit_decoder: directed and random byte streams in both modes.
// A small scoreboard class predicts each result beat; plain tasks drive the streams.
// Depends on vsbd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb_varint_stop_bit_decoder import vsbd_pkg::*; ();

	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_BEATS = 300;
	localparam int MAX_REPORTS = 10;

	class varint_scoreboard;
		logic [63:0] acc;
		logic [3:0]  seen;
		logic        wide;
		res_t        expected_q[$];
		int          errors;

		function new();
			acc = '0;
			seen = '0;
			wide = 1'b1;
			errors = 0;
		endfunction

		function void set_mode(input logic m);
			wide = m;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void queue_result(input logic [63:0] v, input logic [3:0] c, input status_t s);
			res_t r;
			r.value = v;
			r.byte_count = c;
			r.status = s;
			expected_q.push_back(r);
			acc = '0;
			seen = '0;
		endfunction

		// Fold one accepted input beat into the running value.
		function void take_byte(input logic [7:0] b, input logic at_end);
			logic [3:0] lim;
			logic [3:0] cnt;
			int unsigned sh;
			lim = wide ? WIDE_LIMIT : NARROW_LIMIT;
			if (at_end) begin
				queue_result(64'd0, seen, ST_TRUNC);
			end else begin
				sh = 7 * seen;
				acc = acc | ({57'd0, b[6:0]} << sh);
				if (!wide)
					acc[63:32] = '0;
				cnt = seen + 4'd1;
				if (b[7])
					queue_result(acc, cnt, ST_OK);
				else if (cnt >= lim)
					queue_result(64'd0, cnt, ST_OVERLONG);
				else
					seen = cnt;
			end
		endfunction

		function void match_result(input logic [71:0] data, input logic [1:0] user);
			res_t r;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected result value=%h count=%0d status=%0d",
						$realtime, data[63:0], data[67:64], user);
			end else begin
				r = expected_q.pop_front();
				if (data[63:0] !== r.value || data[67:64] !== r.byte_count ||
						data[71:68] !== 4'd0 || user !== r.status) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: mismatch exp value=%h count=%0d status=%0d,",
							$realtime, r.value, r.byte_count, r.status,
							" got value=%h count=%0d pad=%h status=%0d",
							data[63:0], data[67:64], data[71:68], user);
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_wdata = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] data_byte
	logic        s_axis_tuser = 1'b0;   // [0] stream_end
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;          // [63:0] value, [67:64] byte_count, [71:68] zero
	logic [1:0]  m_axis_tuser;          // [1:0] status

	varint_scoreboard sb;
	bit quiet = 1'b0;
	bit hold_rx = 1'b0;
	int n_beats = 0;

	varint_stop_bit_decoder u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end

	// Result side: random stalls, plus one long hold-off on request.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_rx) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
				hold_rx = 1'b0;
			end else begin
				m_axis_tready <= quiet || ($urandom_range(99) >= 16);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.match_result(m_axis_tdata, m_axis_tuser);
	end

	function automatic logic [6:0] rand_payload();
		return 7'($urandom_range(127, 0));
	endfunction

	task automatic send_beat(input logic [7:0] b, input logic at_end);
		while (!quiet && $urandom_range(99) < 16) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= at_end;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.take_byte(b, at_end);
		n_beats++;
	endtask

	// Drain, let the pipe settle, then write the mode register.
	task automatic set_mode(input logic m);
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_mode(m);
	endtask

	// Mostly well-formed values; the rest overlong, cut short, or stray bytes.
	task automatic send_random_value();
		int kind;
		int len;
		int lim;
		kind = $urandom_range(99);
		lim = sb.wide ? WIDE_LIMIT : NARROW_LIMIT;
		if (kind < 78) begin
			len = $urandom_range(lim, 1);
			for (int i = 0; i < len - 1; i++)
				send_beat({1'b0, rand_payload()}, 1'b0);
			send_beat({1'b1, rand_payload()}, 1'b0);
		end else if (kind < 86) begin
			for (int i = 0; i < lim; i++)
				send_beat({1'b0, rand_payload()}, 1'b0);
		end else if (kind < 93) begin
			len = $urandom_range(lim - 1, 0);
			for (int i = 0; i < len; i++)
				send_beat({1'b0, rand_payload()}, 1'b0);
			send_beat(8'($urandom_range(255, 0)), 1'b1);
		end else begin
			send_beat(8'($urandom_range(255, 0)), 1'b0);
		end
	endtask

	initial begin
		bit hold_done;
		hold_done = 1'b0;
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 64-bit mode out of reset: zero value, end with nothing in progress, all ones.
		send_beat(8'h80, 1'b0);
		send_beat(8'h00, 1'b1);
		repeat (9) send_beat(8'h7f, 1'b0);
		send_beat(8'hff, 1'b0);

		// 32-bit mode: all ones with the top payload bits dropped.
		set_mode(1'b0);
		repeat (4) send_beat(8'h7f, 1'b0);
		send_beat(8'hff, 1'b0);

		// Widen mid-value: four bytes held across the switch.
		repeat (4) send_beat(8'h00, 1'b0);
		set_mode(1'b1);
		send_beat(8'h81, 1'b0);

		// Narrow mid-value past the new limit: next byte ends it as overlong.
		repeat (6) send_beat(8'h00, 1'b0);
		set_mode(1'b0);
		send_beat(8'h00, 1'b0);

		for (int p = 0; p < 6; p++) begin
			set_mode((p % 2) == 0);
			quiet = (p == 3);
			n_beats = 0;
			while (n_beats < PHASE_BEATS) begin
				if (p == 1 && n_beats >= 100 && !hold_done) begin
					hold_rx = 1'b1;
					hold_done = 1'b1;
				end
				send_random_value();
			end
			quiet = 1'b0;
		end

		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
